@@ rtl/dcts_pkg.sv @@
`default_nettype none

package dcts_pkg;

    // parameter defaults
    localparam int unsigned DEF_TICK_RATE_HZ = 31250;
    localparam int unsigned DEF_NOTE_SLOTS   = 64;

    // result queue geometry
    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OUT_PTR_W = 2;
    localparam int unsigned OUT_CNT_W = 3;

    // input item kinds
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    // one stored note, already converted to phase step and tick count
    typedef struct packed {
        logic [15:0] step;
        logic [15:0] count;
    } note_t;

    localparam int unsigned NOTE_W = $bits(note_t);

    // one result beat
    typedef struct packed {
        logic left_forward;
        logic right_forward;
        logic left_on;
        logic right_on;
        logic playing;
    } res_t;

    // pipeline occupancy reported by the core
    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } core_stat_t;

endpackage

`default_nettype wire

@@ rtl/dual_channel_tone_sequencer_top.sv @@
`default_nettype none

// channel  handshake              payload
// -------  ---------------------  --------------------------------------------------
// in       in_valid / in_ready    kind, channel, slot, freq_hz, duration_ms
// out      out_valid / out_ready  left_forward, right_forward, left_on, right_on, playing
//
// one beat per cycle sustained while out_ready is held high; a result passes through
// capture and note store read, execute, and the result queue
// in_ready counts the beats in the two pipeline stages plus the 4-entry result
// queue, so a stalled output never blocks the pipeline and never loses a beat
// reset clears playback state and the queue; the note store has no reset and
// each entry must be written before it is played

module dual_channel_tone_sequencer_top #(
    parameter int unsigned TICK_RATE_HZ = dcts_pkg::DEF_TICK_RATE_HZ,
    parameter int unsigned NOTE_SLOTS   = dcts_pkg::DEF_NOTE_SLOTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic        channel,
    input  wire logic [5:0]  slot,
    input  wire logic [15:0] freq_hz,
    input  wire logic [15:0] duration_ms,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             left_forward,
    output logic             right_forward,
    output logic             left_on,
    output logic             right_on,
    output logic             playing
);

    dcts_pkg::core_stat_t               stat;
    logic                               res_valid;
    dcts_pkg::res_t                     res;
    dcts_pkg::res_t                     head;
    logic [dcts_pkg::OUT_CNT_W-1:0]     q_count;
    logic [dcts_pkg::OUT_CNT_W-1:0]     in_flight;

    // credit check over everything that still has to land in the queue
    always_comb
    begin
        in_flight = q_count + dcts_pkg::OUT_CNT_W'(stat.s1_valid)
                            + dcts_pkg::OUT_CNT_W'(stat.s2_valid);
        in_ready  = (in_flight < dcts_pkg::OUT_CNT_W'(dcts_pkg::OUT_DEPTH));
    end

    dcts_core #(
        .TICK_RATE_HZ (TICK_RATE_HZ),
        .NOTE_SLOTS   (NOTE_SLOTS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_valid && in_ready),
        .kind        (kind),
        .channel     (channel),
        .slot        (slot),
        .freq_hz     (freq_hz),
        .duration_ms (duration_ms),
        .stat        (stat),
        .res_valid   (res_valid),
        .res         (res)
    );

    dcts_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (out_ready),
        .valid     (out_valid),
        .head      (head),
        .count     (q_count)
    );

    // result fields
    assign left_forward  = head.left_forward;
    assign right_forward = head.right_forward;
    assign left_on       = head.left_on;
    assign right_on      = head.right_on;
    assign playing       = head.playing;

endmodule

`default_nettype wire

@@ rtl/dcts_ram.sv @@
`default_nettype none

module dcts_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/dcts_out_fifo.sv @@
`default_nettype none

module dcts_out_fifo (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire dcts_pkg::res_t                push_data,
    input  wire logic                          pop,
    output logic                               valid,
    output dcts_pkg::res_t                     head,
    output logic [dcts_pkg::OUT_CNT_W-1:0]     count
);

    dcts_pkg::res_t                    entry_reg [dcts_pkg::OUT_DEPTH];
    logic [dcts_pkg::OUT_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [dcts_pkg::OUT_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [dcts_pkg::OUT_CNT_W-1:0]    count_reg, count_next;
    logic                              do_pop;

    assign do_pop = pop && (count_reg != '0);

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

@@ rtl/dcts_core.sv @@
`default_nettype none

module dcts_core #(
    parameter int unsigned TICK_RATE_HZ = dcts_pkg::DEF_TICK_RATE_HZ,
    parameter int unsigned NOTE_SLOTS   = dcts_pkg::DEF_NOTE_SLOTS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [1:0]           kind,
    input  wire logic                 channel,
    input  wire logic [5:0]           slot,
    input  wire logic [15:0]          freq_hz,
    input  wire logic [15:0]          duration_ms,
    output dcts_pkg::core_stat_t      stat,
    output logic                      res_valid,
    output dcts_pkg::res_t            res
);

    localparam int unsigned IDX_W    = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int unsigned RATE_LOG = $clog2(TICK_RATE_HZ);
    // ceil(2^(32+l) / rate): exact floor division for every dividend below 2^32
    localparam logic [63:0] RECIP =
        ((64'd1 << (32 + RATE_LOG)) + 64'(TICK_RATE_HZ) - 64'd1) / 64'(TICK_RATE_HZ);
    localparam logic [15:0] TICKS_PER_MS = 16'(TICK_RATE_HZ / 1000);
    localparam int unsigned STEP_LSB     = 16 + RATE_LOG;

    // slot index wrapped into the note ring, restoring subtract by constant shifts
    function automatic logic [IDX_W-1:0] slot_wrap(input logic [5:0] s);
        logic [16:0] r;
        r = 17'(s);
        for (int k = 5; k >= 0; k--)
        begin
            if (r >= (17'(NOTE_SLOTS) << k))
            begin
                r = r - (17'(NOTE_SLOTS) << k);
            end
        end
        return r[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(NOTE_SLOTS - 1)) ? '0 : i + 1'b1;
    endfunction

    // stage 1: captured input beat
    logic          s1_valid_reg;
    logic [1:0]    s1_kind_reg;
    logic          s1_channel_reg;
    logic [5:0]    s1_slot_reg;
    logic [15:0]   s1_freq_reg;
    logic [15:0]   s1_dur_reg;

    // stage 2: beat waiting on its note reads
    logic          s2_valid_reg;
    logic [1:0]    s2_kind_reg;

    // playback state, index 0 left, 1 right
    logic [IDX_W-1:0] idx_reg   [2];
    logic [IDX_W-1:0] idx_next  [2];
    logic [15:0]      count_reg [2];
    logic [15:0]      count_next[2];
    logic [15:0]      step_reg  [2];
    logic [15:0]      step_next [2];
    logic [15:0]      phase_reg [2];
    logic [15:0]      phase_next[2];
    logic             dir_reg   [2];
    logic             dir_next  [2];
    logic             active_reg, active_next;

    logic [15:0]      cnt_dec   [2];
    dcts_pkg::note_t  rd_note   [2];
    logic [IDX_W-1:0] rd_addr   [2];

    logic [49:0]      step_prod;
    logic [31:0]      count_prod;
    dcts_pkg::note_t  wr_note;
    logic [IDX_W-1:0] wr_addr;

    // note conversion on the write path, the store write registers the products
    always_comb
    begin
        step_prod     = s1_freq_reg * RECIP[33:0];
        count_prod    = s1_dur_reg * TICKS_PER_MS;
        wr_note.step  = step_prod[STEP_LSB +: 16];
        wr_note.count = count_prod[15:0];
        wr_addr       = slot_wrap(s1_slot_reg);
    end

    // one note store per channel, read at slot 0 on a start, else at idx_next
    for (genvar ch = 0; ch < 2; ch++)
    begin : g_store
        logic [dcts_pkg::NOTE_W-1:0] rd_word;

        assign rd_addr[ch] = (s1_kind_reg == dcts_pkg::KIND_START) ? '0 : idx_next[ch];

        dcts_ram #(
            .WIDTH (dcts_pkg::NOTE_W),
            .DEPTH (NOTE_SLOTS)
        ) u_ram (
            .clk     (clk),
            .wr_en   (s1_valid_reg && (s1_kind_reg == dcts_pkg::KIND_WRITE)
                      && (s1_channel_reg == 1'(ch))),
            .wr_addr (wr_addr),
            .wr_data (wr_note),
            .rd_addr (rd_addr[ch]),
            .rd_data (rd_word)
        );

        assign rd_note[ch] = dcts_pkg::note_t'(rd_word);
    end

    // execute the stage 2 beat
    always_comb
    begin
        active_next = active_reg;
        for (int ch = 0; ch < 2; ch++)
        begin
            idx_next[ch]   = idx_reg[ch];
            count_next[ch] = count_reg[ch];
            step_next[ch]  = step_reg[ch];
            phase_next[ch] = phase_reg[ch];
            dir_next[ch]   = dir_reg[ch];
            cnt_dec[ch]    = count_reg[ch] - 16'd1;
        end

        if (s2_valid_reg)
        begin
            unique case (s2_kind_reg)
                dcts_pkg::KIND_START:
                begin
                    for (int ch = 0; ch < 2; ch++)
                    begin
                        step_next[ch]  = rd_note[ch].step;
                        count_next[ch] = rd_note[ch].count;
                        idx_next[ch]   = idx_inc('0);
                        phase_next[ch] = '0;
                        dir_next[ch]   = 1'b1;
                    end
                    active_next = (rd_note[0].count != 16'd0);
                end
                dcts_pkg::KIND_TICK:
                begin
                    if (active_reg)
                    begin
                        for (int ch = 0; ch < 2; ch++)
                        begin
                            if (cnt_dec[ch] == 16'd0)
                            begin
                                step_next[ch]  = rd_note[ch].step;
                                count_next[ch] = rd_note[ch].count;
                                idx_next[ch]   = idx_inc(idx_reg[ch]);
                            end
                            else
                            begin
                                count_next[ch] = cnt_dec[ch];
                            end
                            phase_next[ch] = phase_reg[ch] + step_next[ch];
                            dir_next[ch]   = phase_next[ch][15];
                        end
                        active_next = (count_next[0] != 16'd0);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // pipeline control and playback state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            active_reg   <= 1'b0;
            for (int ch = 0; ch < 2; ch++)
            begin
                idx_reg[ch]   <= '0;
                count_reg[ch] <= '0;
                step_reg[ch]  <= '0;
                phase_reg[ch] <= '0;
                dir_reg[ch]   <= 1'b1;
            end
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            active_reg   <= active_next;
            for (int ch = 0; ch < 2; ch++)
            begin
                idx_reg[ch]   <= idx_next[ch];
                count_reg[ch] <= count_next[ch];
                step_reg[ch]  <= step_next[ch];
                phase_reg[ch] <= phase_next[ch];
                dir_reg[ch]   <= dir_next[ch];
            end
        end
    end

    // beat payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg    <= kind;
            s1_channel_reg <= channel;
            s1_slot_reg    <= slot;
            s1_freq_reg    <= freq_hz;
            s1_dur_reg     <= duration_ms;
        end
        s2_kind_reg <= s1_kind_reg;
    end

    // result of the executed beat
    always_comb
    begin
        res_valid         = s2_valid_reg;
        res.left_forward  = dir_next[0];
        res.right_forward = dir_next[1];
        res.left_on       = active_next && (step_next[0] != 16'd0);
        res.right_on      = active_next && (step_next[1] != 16'd0);
        res.playing       = active_next;
        stat.s1_valid     = s1_valid_reg;
        stat.s2_valid     = s2_valid_reg;
    end

endmodule

`default_nettype wire
